@@ design/frot_pkg.sv @@
// Shared types and constants for the quarter-turn frame rotator.
// Used by the front, back and top-level modules; depends on nothing.
package frot_pkg;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_BITS      = 10;
  localparam int unsigned PORT_PIX_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ANGLE_NONE = 2'd0,
    ANGLE_90   = 2'd1,
    ANGLE_180  = 2'd2,
    ANGLE_270  = 2'd3
  } angle_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    last;
  } cmd_ctrl_t;

endpackage

@@ design/frot_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module frot_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/frot_fifo.sv @@
// Short register FIFO carrying commands from the front to the back.
// No dependencies.
module frot_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entry_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ design/frot_front.sv @@
// Front end: holds configuration and frame counters, classifies each item and
// turns it into a store write or read command. Depends on frot_pkg.
module frot_front import frot_pkg::*; #(
  parameter int unsigned MAX_DIM  = 512,
  parameter int unsigned PIX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index_i,
  input  logic [CFG_BITS-1:0]                 cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [PORT_PIX_BITS-1:0]            pixel_in_i,
  input  logic                                cmd_full_i,
  output logic                                cmd_push_o,
  output cmd_ctrl_t                           cmd_ctrl_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  cmd_addr_o,
  output logic [PIX_BITS-1:0]                 cmd_pixel_o
);

  localparam int unsigned DIM_BITS  = $clog2(MAX_DIM);
  localparam int unsigned DIMV_BITS = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_BITS = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned POS_BITS  = $clog2(MAX_DIM * MAX_DIM + 1);

  angle_e               angle_q;
  logic [CFG_BITS-1:0]  width_q, height_q;
  logic [POS_BITS-1:0]  load_pos_q, load_pos_d;
  logic [DIM_BITS-1:0]  row_q, row_d, col_q, col_d;

  logic [DIMV_BITS-1:0] w, h, dw, dh, rowx, colx;
  logic [DIM_BITS-1:0]  src_r, src_c;
  logic [POS_BITS-1:0]  area;
  logic                 full_frame, is_last, accept;

  function automatic logic [DIMV_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
    logic [CFG_BITS:0] vx;
    vx = {1'b0, v};
    if (v == '0) begin
      return DIMV_BITS'(1);
    end else if (vx > (CFG_BITS + 1)'(MAX_DIM)) begin
      return DIMV_BITS'(MAX_DIM);
    end
    return DIMV_BITS'(v);
  endfunction

  assign w          = clamp_dim(width_q);
  assign h          = clamp_dim(height_q);
  assign area       = POS_BITS'(w) * POS_BITS'(h);
  assign full_frame = (load_pos_q >= area);
  assign rowx       = DIMV_BITS'(row_q);
  assign colx       = DIMV_BITS'(col_q);
  assign dw         = (angle_q == ANGLE_90 || angle_q == ANGLE_270) ? h : w;
  assign dh         = (angle_q == ANGLE_90 || angle_q == ANGLE_270) ? w : h;
  assign is_last    = (DIMV_BITS'(rowx + 1'b1) == dh) && (DIMV_BITS'(colx + 1'b1) == dw);

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    case (angle_q)
      ANGLE_90: begin
        src_r = col_q;
        src_c = DIM_BITS'(w - 1'b1 - rowx);
      end
      ANGLE_180: begin
        src_r = DIM_BITS'(h - 1'b1 - rowx);
        src_c = DIM_BITS'(w - 1'b1 - colx);
      end
      ANGLE_270: begin
        src_r = DIM_BITS'(h - 1'b1 - colx);
        src_c = row_q;
      end
      default: begin
        src_r = row_q;
        src_c = col_q;
      end
    endcase
  end

  always_comb begin
    load_pos_d        = load_pos_q;
    row_d             = row_q;
    col_d             = col_q;
    cmd_push_o        = 1'b0;
    cmd_ctrl_o.op     = CMD_WRITE;
    cmd_ctrl_o.last   = 1'b0;
    cmd_addr_o        = ADDR_BITS'(load_pos_q);
    cmd_pixel_o       = pixel_in_i[PIX_BITS-1:0];
    if (opcode_e'(opcode_i) == OP_EMIT) begin
      cmd_ctrl_o.op   = CMD_READ;
      cmd_ctrl_o.last = is_last;
      cmd_addr_o      = ADDR_BITS'(src_r) * ADDR_BITS'(w) + ADDR_BITS'(src_c);
    end
    if (accept) begin
      if (opcode_e'(opcode_i) == OP_LOAD) begin
        if (!full_frame) begin
          cmd_push_o = 1'b1;
          load_pos_d = load_pos_q + 1'b1;
        end
      end else if (full_frame) begin
        cmd_push_o = 1'b1;
        if (is_last) begin
          load_pos_d = '0;
          row_d      = '0;
          col_d      = '0;
        end else if (DIMV_BITS'(colx + 1'b1) >= dw) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
    if (cfg_we_i && (cfg_index_i == REG_ANGLE_MODE || cfg_index_i == REG_FRAME_WIDTH ||
                     cfg_index_i == REG_FRAME_HEIGHT)) begin
      load_pos_d = '0;
      row_d      = '0;
      col_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q    <= ANGLE_NONE;
      width_q    <= CFG_BITS'(160);
      height_q   <= CFG_BITS'(160);
      load_pos_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      load_pos_q <= load_pos_d;
      row_q      <= row_d;
      col_q      <= col_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ANGLE_MODE:   angle_q  <= angle_e'(cfg_data_i[1:0]);
          REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/frot_back.sv @@
// Back end: carries out queued commands on the frame store and holds the
// result in an output register. Depends on frot_pkg and frot_ram.
module frot_back import frot_pkg::*; #(
  parameter int unsigned MAX_DIM  = 512,
  parameter int unsigned PIX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  cmd_ctrl_t                           cmd_ctrl_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  cmd_addr_i,
  input  logic [PIX_BITS-1:0]                 cmd_pixel_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [PORT_PIX_BITS-1:0]            pixel_out_o,
  output logic                                last_of_frame_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  logic                rd_pend_q, rd_last_q;
  logic                out_valid_q, out_valid_d;
  logic [PIX_BITS-1:0] out_pix_q;
  logic                out_last_q;
  logic [PIX_BITS-1:0] rd_data;
  logic                can_read, ram_we, ram_re;

  assign can_read  = !rd_pend_q && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = cmd_valid_i && (cmd_ctrl_i.op == CMD_WRITE || can_read);
  assign ram_we    = cmd_pop_o && (cmd_ctrl_i.op == CMD_WRITE);
  assign ram_re    = cmd_pop_o && (cmd_ctrl_i.op == CMD_READ);

  frot_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_addr_i),
    .wdata_i (cmd_pixel_i),
    .re_i    (ram_re),
    .raddr_i (cmd_addr_i),
    .rdata_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= ram_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_last_q <= cmd_ctrl_i.last;
    end
    if (rd_pend_q) begin
      out_pix_q  <= rd_data;
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_out_o     = PORT_PIX_BITS'(out_pix_q);
  assign last_of_frame_o = out_last_q;

endmodule

@@ design/frame_rotator_quarter_turns.sv @@
// Quarter-turn frame rotator top level: front end, command queue, back end.
// Depends on frot_pkg, frot_front, frot_fifo and frot_back.
//
// Usage: set angle_mode, frame_width and frame_height through the write port
// (index 0, 1, 2) while idle; each such write restarts the frame. Then send
// width*height load items (opcode 0) in source raster order, followed by
// emit items (opcode 1), each of which returns one rotated pixel in
// destination raster order; the final one carries last_of_frame and rearms
// the block for the next frame. Emits before the frame is full and loads
// after it is full are consumed without a result.
// Input channel: in_valid_i/in_ready_o; output channel out_valid_o/out_ready_i.
// Throughput: one load per cycle while the command queue has room; emits are
// slower, as the frame store has a single outstanding read feeding the output
// register. An emit's result follows the queue write at the edge that accepts
// it, then the store read, then the output register.
// Reset clears counters and registers to angle 0, 160 x 160; store contents
// are undefined until loaded. When the receiver stalls, the result is held,
// reads stop and the two-entry command queue fills, then in_ready_o drops.
module frame_rotator_quarter_turns import frot_pkg::*; #(
  parameter int unsigned MAX_DIM    = 512,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [CFG_BITS-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       opcode_i,
  input  logic [PORT_PIX_BITS-1:0]   pixel_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [PORT_PIX_BITS-1:0]   pixel_out_o,
  output logic                       last_of_frame_o
);

  localparam int unsigned PW        = (PIXEL_BITS < PORT_PIX_BITS) ? PIXEL_BITS
                                                                   : PORT_PIX_BITS;
  localparam int unsigned ADDR_BITS = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned CTRL_BITS = $bits(cmd_ctrl_t);
  localparam int unsigned Q_WIDTH   = CTRL_BITS + ADDR_BITS + PW;

  cmd_ctrl_t            f_ctrl, b_ctrl;
  logic [ADDR_BITS-1:0] f_addr, b_addr;
  logic [PW-1:0]        f_pix, b_pix;
  logic                 f_push, q_full, q_valid, b_pop;
  logic [Q_WIDTH-1:0]   q_wdata, q_rdata;

  frot_front #(
    .MAX_DIM  (MAX_DIM),
    .PIX_BITS (PW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .pixel_in_i  (pixel_in_i),
    .cmd_full_i  (q_full),
    .cmd_push_o  (f_push),
    .cmd_ctrl_o  (f_ctrl),
    .cmd_addr_o  (f_addr),
    .cmd_pixel_o (f_pix)
  );

  assign q_wdata = {f_ctrl, f_addr, f_pix};

  frot_fifo #(
    .WIDTH (Q_WIDTH),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign b_ctrl = cmd_ctrl_t'(q_rdata[Q_WIDTH-1 -: CTRL_BITS]);
  assign b_addr = q_rdata[PW +: ADDR_BITS];
  assign b_pix  = q_rdata[PW-1:0];

  frot_back #(
    .MAX_DIM  (MAX_DIM),
    .PIX_BITS (PW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_ctrl_i      (b_ctrl),
    .cmd_addr_i      (b_addr),
    .cmd_pixel_i     (b_pix),
    .cmd_pop_o       (b_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_out_o     (pixel_out_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for frame_rotator_quarter_turns: loads frames, reads them back
// rotated and compares every transfer against an in-bench rotation predictor.
// Depends on frot_pkg and the frame_rotator_quarter_turns RTL.
module tb_top;
  import frot_pkg::*;

  localparam int unsigned MAX_SIDE  = 512;
  localparam int unsigned RUN_LIMIT = 5_000_000;
  localparam int unsigned SETTLE    = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    opcode_e     op;
    logic [15:0] pix;
  } rot_item_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last;
  } rot_pixel_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_BITS-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     opcode_i;
  logic [PORT_PIX_BITS-1:0] pixel_in_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [PORT_PIX_BITS-1:0] pixel_out_o;
  logic                     last_of_frame_o;

  rot_item_t   pending_items[$];
  rot_pixel_t  expected_pixels[$];
  bit   [15:0] frame_copy [0:MAX_SIDE*MAX_SIDE-1];
  int unsigned load_count;
  int unsigned out_row;
  int unsigned out_col;
  angle_e      cur_angle;
  logic [9:0]  cur_width;
  logic [9:0]  cur_height;
  int unsigned idle_pct;
  int unsigned error_count;
  int unsigned frame_items;
  bit          in_taken;

  frame_rotator_quarter_turns #(
    .MAX_DIM    (MAX_SIDE),
    .PIXEL_BITS (16)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .pixel_in_i      (pixel_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_out_o     (pixel_out_o),
    .last_of_frame_o (last_of_frame_o)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_ANGLE_MODE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_LOAD;
    pixel_in_i  = '0;
    out_ready_i = 1'b0;
    idle_pct    = 36;
    error_count = 0;
    frame_items = 0;
    in_taken    = 1'b0;
    load_count  = 0;
    out_row     = 0;
    out_col     = 0;
    cur_angle   = ANGLE_NONE;
    cur_width   = 10'd160;
    cur_height  = 10'd160;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        repeat (3) @(negedge clk_i);
        rst_ni = 1'b1;
      end
    join_none
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [9:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic void predict_rotated_pixel(input opcode_e op, input logic [15:0] pix);
    int unsigned w, h, dw, dh, r, c;
    rot_pixel_t  res;
    w = clamp_dim(cur_width);
    h = clamp_dim(cur_height);
    if (op == OP_LOAD) begin
      if (load_count < w * h) begin
        frame_copy[load_count] = pix;
        load_count++;
      end
    end else if (load_count >= w * h) begin
      if (cur_angle == ANGLE_90 || cur_angle == ANGLE_270) begin
        dw = h;
        dh = w;
      end else begin
        dw = w;
        dh = h;
      end
      if (out_row >= dh || out_col >= dw) begin
        out_row = 0;
        out_col = 0;
      end
      case (cur_angle)
        ANGLE_90: begin
          r = out_col;
          c = w - 1 - out_row;
        end
        ANGLE_180: begin
          r = h - 1 - out_row;
          c = w - 1 - out_col;
        end
        ANGLE_270: begin
          r = h - 1 - out_col;
          c = out_row;
        end
        default: begin
          r = out_row;
          c = out_col;
        end
      endcase
      res.pixel = frame_copy[r * w + c];
      res.last  = (out_row == dh - 1) && (out_col == dw - 1);
      expected_pixels.push_back(res);
      if (res.last) begin
        load_count = 0;
        out_row    = 0;
        out_col    = 0;
      end else if (out_col + 1 >= dw) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_item(input opcode_e op, input logic [15:0] pix);
    rot_item_t it;
    it.op  = op;
    it.pix = pix;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [9:0] val);
    bit restart;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    restart = 1'b1;
    case (idx)
      REG_ANGLE_MODE:   cur_angle  = angle_e'(val[1:0]);
      REG_FRAME_WIDTH:  cur_width  = val;
      REG_FRAME_HEIGHT: cur_height = val;
      default:          restart    = 1'b0;
    endcase
    if (restart) begin
      load_count = 0;
      out_row    = 0;
      out_col    = 0;
    end
  endtask

  task automatic setup_frame(input angle_e angle, input logic [9:0] w, input logic [9:0] h);
    logic [9:0] val;
    wait_idle();
    val      = 10'($urandom);
    val[1:0] = angle;
    write_reg(REG_ANGLE_MODE, val);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // Load a frame then drain it; noise adds ignored items, cut stops part way.
  task automatic queue_frame(input int unsigned area, input bit noisy, input bit cut);
    int unsigned stop, i;
    stop = cut ? $urandom_range(area * 2 - 1) : area * 2;
    for (i = 0; i < stop; i++) begin
      if (noisy && $urandom_range(15) == 0)
        push_item(i < area ? OP_EMIT : OP_LOAD, 16'($urandom));
      push_item(i < area ? OP_LOAD : OP_EMIT, 16'($urandom));
    end
    frame_items += stop;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_rotated_pixel(opcode_e'(opcode_i), pixel_in_i);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_items
    rot_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid_i <= 1'b1;
        opcode_i   <= nxt.op;
        pixel_in_i <= nxt.pix;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    rot_pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer pixel_out=%h last=%b",
                                  pixel_out_o, last_of_frame_o));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out_o !== want.pixel)
          report_mismatch($sformatf("pixel_out=%h want %h", pixel_out_o, want.pixel));
        if (last_of_frame_o !== want.last)
          report_mismatch($sformatf("last_of_frame=%b want %b", last_of_frame_o, want.last));
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, area, n, f;
    bit          cut;
    @(posedge rst_ni);
    @(posedge clk_i);

    write_reg(REG_FRAME_WIDTH, 10'd2);
    write_reg(REG_FRAME_HEIGHT, 10'd2);
    push_item(OP_EMIT, 16'h0000);
    push_item(OP_LOAD, 16'h0000);
    push_item(OP_LOAD, 16'hFFFF);
    push_item(OP_EMIT, 16'hFFFF);
    push_item(OP_LOAD, 16'h8001);
    push_item(OP_LOAD, 16'h7FFE);
    push_item(OP_LOAD, 16'hA5A5);
    repeat (4) push_item(OP_EMIT, 16'h0000);
    push_item(OP_EMIT, 16'h5A5A);

    // restart a half-loaded frame by a register write
    repeat (3) push_item(OP_LOAD, 16'($urandom));
    wait_idle();
    write_reg(REG_ANGLE_MODE, 10'(ANGLE_90));
    push_item(OP_LOAD, 16'h1234);
    push_item(OP_LOAD, 16'hFEDC);
    wait_idle();
    write_reg(REG_UNUSED, 10'h3FF);
    push_item(OP_LOAD, 16'h0F0F);
    push_item(OP_LOAD, 16'hF0F0);
    repeat (4) push_item(OP_EMIT, 16'($urandom));

    setup_frame(ANGLE_180, 10'd0, 10'd0);
    queue_frame(1, 1'b0, 1'b0);

    // width clamps to the maximum; fill the frame, drain only its start
    setup_frame(ANGLE_90, 10'd1023, 10'd1);
    repeat (MAX_SIDE) push_item(OP_LOAD, 16'($urandom));
    repeat (16) push_item(OP_EMIT, 16'($urandom));

    setup_frame(ANGLE_270, 10'd3, 10'd7);
    queue_frame(21, 1'b1, 1'b0);

    frame_items = 0;
    while (frame_items < 300) begin
      wait_idle();
      idle_pct = (frame_items >= 100 && frame_items < 200) ? 0 : 36;
      w = $urandom_range(8);
      h = $urandom_range(8);
      setup_frame(angle_e'($urandom_range(3)), 10'(w), 10'(h));
      area = clamp_dim(10'(w)) * clamp_dim(10'(h));
      n    = $urandom_range(1, 3);
      cut  = 1'b0;
      for (f = 0; f < n && !cut; f++) begin
        cut = ($urandom_range(7) == 0);
        queue_frame(area, 1'b1, cut);
      end
    end

    wait_idle();
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d transfers never arrived", expected_pixels.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/frot_pkg.sv
design/frot_ram.sv
design/frot_fifo.sv
design/frot_front.sv
design/frot_back.sv
design/frame_rotator_quarter_turns.sv
sim/tb_top.sv
